// ===== rtl/qwlfo_pkg.sv =====
// ----------------------------------------------------------------------------
// qwlfo_pkg
// Shared widths, codes and constants for the quarter-wave LFO with depth.
// ----------------------------------------------------------------------------
package qwlfo_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned ENTRY_W    = 6;
  localparam int unsigned PHASE_W    = 10;
  localparam int unsigned SHAPE_W    = 2;
  localparam int unsigned DEPTH_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TABLE_DEPTH = 1 << ENTRY_W;

  localparam logic [PHASE_W-1:0] INDEX_TOP    = PHASE_W'(63);
  localparam logic [PHASE_W-1:0] INDEX_BOTTOM = PHASE_W'(0);

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = {SAMPLE_W{1'b1}};
  localparam logic [DEPTH_W-1:0]  DEPTH_FULL = {DEPTH_W{1'b1}};
  localparam logic [DEPTH_W-1:0]  DEPTH_NONE = '0;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic TBL_TRIANGLE = 1'b0;
  localparam logic TBL_SINE     = 1'b1;

  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_ENABLE = 2'd2;

endpackage

// ===== rtl/quarter_wave_lfo_with_depth.sv =====
// ----------------------------------------------------------------------------
// quarter_wave_lfo_with_depth
// Quarter-wave table LFO with half-cycle inversion and a depth stage.
// ----------------------------------------------------------------------------
// One word per cycle while in_stall_o is low: a tick or a table write is taken
// every clock. A tick goes through the read and output registers: the read
// stage reads the two 64-entry quarter tables at the current phase index, the
// output stage selects the shape, applies the half-cycle inversion and, with
// depth enabled, the 10x8 depth multiply. Table writes give no output word.
// Both tables read as undefined until loaded, so fill them before the first
// tick. Register writes are always taken and must be issued only while idle.
// ----------------------------------------------------------------------------
module quarter_wave_lfo_with_depth
  import qwlfo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic                  table_select_i,
  input  logic [ENTRY_W-1:0]    entry_index_i,
  input  logic [SAMPLE_W-1:0]   entry_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]   duty_value_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SHAPE_W-1:0]  shape_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic                depth_en_q;

  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                fall_q, fall_d;
  logic                half_q, half_d;

  logic [SAMPLE_W-1:0] tri_mem [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] sine_mem [TABLE_DEPTH];

  logic                s1_vld_q;
  logic                s1_half_q;
  logic [SAMPLE_W-1:0] tri_rd_q;
  logic [SAMPLE_W-1:0] sine_rd_q;

  logic                out_vld_q;
  logic [SAMPLE_W-1:0] duty_q, duty_d;

  logic                in_acc, tick_acc, write_acc;
  logic                out_adv, s1_adv;
  logic                hit_top, hit_bot;
  logic [ENTRY_W-1:0]  rd_addr;

  logic [SAMPLE_W-1:0]         raw_val, inv_val, scaled;
  logic [SAMPLE_W+DEPTH_W-1:0] prod;

  assign cfg_ready_o = 1'b1;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign s1_adv     = !s1_vld_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (opcode_i == OP_TICK);
  assign write_acc  = in_acc && (opcode_i == OP_WRITE);

  // phase walk
  always_comb begin
    hit_top = (phase_q == INDEX_TOP);
    hit_bot = (phase_q == INDEX_BOTTOM);
    fall_d  = fall_q;
    half_d  = half_q;
    if (hit_top) begin
      fall_d = 1'b1;
    end else if (hit_bot) begin
      fall_d = 1'b0;
      half_d = ~half_q;
    end
    phase_d = fall_d ? (phase_q - PHASE_W'(1)) : (phase_q + PHASE_W'(1));
  end

  assign rd_addr = phase_q[ENTRY_W-1:0];

  // quarter tables
  always_ff @(posedge clk_i) begin
    if (write_acc && (table_select_i == TBL_TRIANGLE)) begin
      tri_mem[entry_index_i] <= entry_value_i;
    end
    if (write_acc && (table_select_i == TBL_SINE)) begin
      sine_mem[entry_index_i] <= entry_value_i;
    end
    if (tick_acc) begin
      tri_rd_q  <= tri_mem[rd_addr];
      sine_rd_q <= sine_mem[rd_addr];
      s1_half_q <= half_d;
    end
  end

  // shape, inversion and depth
  always_comb begin
    case (shape_q)
      SHAPE_TRIANGLE: raw_val = tri_rd_q;
      SHAPE_SINE:     raw_val = sine_rd_q;
      SHAPE_SQUARE:   raw_val = FULL_SCALE;
      default:        raw_val = FULL_SCALE;
    endcase
    inv_val = s1_half_q ? (FULL_SCALE - raw_val) : raw_val;
    prod    = (SAMPLE_W+DEPTH_W)'(inv_val) * (SAMPLE_W+DEPTH_W)'(depth_q);
    scaled  = prod[SAMPLE_W+DEPTH_W-1:DEPTH_W];
    if (!depth_en_q) begin
      duty_d = inv_val;
    end else if (depth_q == DEPTH_FULL) begin
      duty_d = FULL_SCALE - inv_val;
    end else if (depth_q == DEPTH_NONE) begin
      duty_d = FULL_SCALE;
    end else begin
      duty_d = FULL_SCALE - scaled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && out_adv) begin
      duty_q <= duty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q    <= SHAPE_SINE;
      depth_q    <= DEPTH_NONE;
      depth_en_q <= 1'b1;
      phase_q    <= INDEX_BOTTOM;
      fall_q     <= 1'b0;
      half_q     <= 1'b0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_WAVE_SHAPE:   shape_q    <= cfg_data_i[SHAPE_W-1:0];
          REG_MOD_DEPTH:    depth_q    <= cfg_data_i[DEPTH_W-1:0];
          REG_DEPTH_ENABLE: depth_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (tick_acc) begin
        phase_q <= phase_d;
        fall_q  <= fall_d;
        half_q  <= half_d;
      end
      if (s1_adv) begin
        s1_vld_q <= tick_acc;
      end
      if (out_adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign duty_value_o = duty_q;

  a_top_turns_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && (phase_q == INDEX_TOP)) |=> fall_q)
    else $error("phase did not turn down at top");

  a_bottom_flips_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && hit_bot && !hit_top) |=> (half_q != $past(half_q)))
    else $error("half-cycle did not flip at bottom");

  a_write_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (write_acc) |=> ($stable(phase_q) && $stable(fall_q) && $stable(half_q)))
    else $error("table write moved the phase");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while pipeline full");

endmodule
